[hw/rtl/mrdd_pkg.sv]
// Shared widths and constants for the masked record delta decoder.
package mrdd_pkg;

    localparam int BYTE_W           = 8;
    localparam int WORD_W           = 64;
    localparam int HALF_W           = 32;
    localparam int WORD_BYTES       = WORD_W / BYTE_W;
    localparam int LANE_W           = $clog2(WORD_BYTES);
    localparam int MAX_RECORD_WORDS = 512;
    localparam int IDX_W            = $clog2(MAX_RECORD_WORDS);
    localparam int FILL_W           = IDX_W + 1;
    localparam int CFG_W            = 13;
    localparam int GROUP_WORDS      = 8;
    localparam int GROUP_W          = $clog2(GROUP_WORDS);

    localparam logic [CFG_W-1:0] RECORD_BYTES_RESET = CFG_W'(52);
    localparam logic [CFG_W-1:0] MIN_RECORD_BYTES   = CFG_W'(4);
    localparam logic [CFG_W-1:0] MAX_RECORD_BYTES   = CFG_W'(MAX_RECORD_WORDS * WORD_BYTES);

endpackage

[hw/rtl/masked_record_delta_decoder_unit.sv]
// Masked record delta decoder: byte stream in, decoded record words out.
// Path: a final data byte goes to the emit register, then EMIT loads the output register;
//   an unflagged header or empty mask byte first passes the store read (COPY_RD, MASK_RD);
//   each further copied word of the same run takes a store read, then an emit. Flagged header
//   and non-final data bytes keep IDLE taking bytes; others wait for the store loop and m_ready.
// Reset: control state clears synchronously; a fill count reads unwritten store entries as zero.
module masked_record_delta_decoder_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel: record_bytes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mrdd_pkg::CFG_W-1:0]    cfg_data,
    // compressed byte input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mrdd_pkg::BYTE_W-1:0]   s_stream_byte,
    // decoded word output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mrdd_pkg::WORD_W-1:0]   m_word_value,
    output logic [mrdd_pkg::IDX_W-1:0]    m_word_index,
    output logic                          m_half_word,
    output logic                          m_record_end,
    output logic                          m_last_in_run
);

    // Sequencer: IDLE takes bytes; COPY_RD and MASK_RD consume the registered
    // store read; EMIT writes one word to the output register and the store.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY_RD,
        ST_MASK_RD,
        ST_EMIT
    } state_t;

    // Decode phase: what the next stream byte means. The unused code acts as HEADER.
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_MASK   = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    state_t                            state_reg;
    phase_t                            phase_reg;
    logic [mrdd_pkg::CFG_W-1:0]        record_bytes_reg;
    logic [mrdd_pkg::IDX_W-1:0]        pos_reg;
    logic [mrdd_pkg::BYTE_W-1:0]       header_reg;
    logic [mrdd_pkg::BYTE_W-1:0]       mask_reg;
    logic [mrdd_pkg::BYTE_W-1:0]       byte_reg;
    logic [mrdd_pkg::WORD_W-1:0]       gathered_reg;
    logic [mrdd_pkg::WORD_W-1:0]       emit_val_reg;
    logic [mrdd_pkg::FILL_W-1:0]       fill_reg;

    logic                              m_valid_reg;
    logic [mrdd_pkg::WORD_W-1:0]       m_word_value_reg;
    logic [mrdd_pkg::IDX_W-1:0]        m_word_index_reg;
    logic                              m_half_word_reg;
    logic                              m_record_end_reg;
    logic                              m_last_in_run_reg;

    // Record store: one word per record position, registered read.
    logic [mrdd_pkg::WORD_W-1:0]       store_mem [mrdd_pkg::MAX_RECORD_WORDS];
    logic [mrdd_pkg::WORD_W-1:0]       rd_data_reg;
    logic                              rd_hit_reg;
    logic                              rd_en;
    logic [mrdd_pkg::IDX_W-1:0]        rd_addr;
    logic                              wr_en;

    // Record geometry from the configured byte count.
    logic [mrdd_pkg::CFG_W-1:0]        eff_bytes;
    logic [mrdd_pkg::FILL_W-1:0]       words;
    logic                              has_half;

    // Per-byte decode helpers.
    logic                              cfg_fire;
    logic                              s_fire;
    logic                              out_free;
    logic                              wrap;
    logic [mrdd_pkg::IDX_W-1:0]        pos_cur;
    phase_t                            phase_cur;
    logic [mrdd_pkg::LANE_W-1:0]       lane;
    logic [mrdd_pkg::BYTE_W-1:0]       mask_left;
    logic [mrdd_pkg::WORD_W-1:0]       merged;
    logic [mrdd_pkg::WORD_W-1:0]       rd_word;

    // Emit helpers.
    logic                              rec_end;
    logic                              grp_end;
    logic                              next_flag;
    logic                              run_stop;
    logic                              emit_half;
    logic [mrdd_pkg::WORD_W-1:0]       emit_word;
    logic [mrdd_pkg::GROUP_W-1:0]      next_slot;

    // ------------------------------------------------------------------
    // Handshakes. Configuration wins over a byte in the same cycle.
    // ------------------------------------------------------------------
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_word_value  = m_word_value_reg;
    assign m_word_index  = m_word_index_reg;
    assign m_half_word   = m_half_word_reg;
    assign m_record_end  = m_record_end_reg;
    assign m_last_in_run = m_last_in_run_reg;

    // ------------------------------------------------------------------
    // Geometry: clear the low two bits, clamp to 4..4096 bytes.
    // ------------------------------------------------------------------
    always_comb begin
        eff_bytes = record_bytes_reg & ~mrdd_pkg::CFG_W'(3);
        if (eff_bytes < mrdd_pkg::MIN_RECORD_BYTES) begin
            eff_bytes = mrdd_pkg::MIN_RECORD_BYTES;
        end else if (eff_bytes > mrdd_pkg::MAX_RECORD_BYTES) begin
            eff_bytes = mrdd_pkg::MAX_RECORD_BYTES;
        end
    end

    assign has_half = eff_bytes[2];
    assign words    = mrdd_pkg::FILL_W'((eff_bytes + mrdd_pkg::CFG_W'(7)) >> 3);

    // Restart at word 0 on a header when the position ran past the record.
    assign wrap      = {1'b0, pos_reg} >= words;
    assign pos_cur   = wrap ? '0 : pos_reg;
    assign phase_cur = wrap ? PH_HEADER : phase_reg;

    // ------------------------------------------------------------------
    // Data byte merge: replace the byte at the lowest pending mask bit.
    // ------------------------------------------------------------------
    always_comb begin
        lane = '0;
        for (int i = mrdd_pkg::WORD_BYTES - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                lane = mrdd_pkg::LANE_W'(i);
            end
        end
    end

    assign mask_left = mask_reg & (mask_reg - mrdd_pkg::BYTE_W'(1));

    always_comb begin
        merged = gathered_reg;
        for (int i = 0; i < mrdd_pkg::WORD_BYTES; i++) begin
            if (lane == mrdd_pkg::LANE_W'(i)) begin
                merged[i*mrdd_pkg::BYTE_W +: mrdd_pkg::BYTE_W] = s_stream_byte;
            end
        end
    end

    // Entries at or beyond the fill count were never written since reset.
    assign rd_word = rd_hit_reg ? rd_data_reg : '0;

    // ------------------------------------------------------------------
    // Emit decisions for the word at pos_reg.
    // ------------------------------------------------------------------
    assign rec_end   = ({1'b0, pos_reg} + mrdd_pkg::FILL_W'(1)) >= words;
    assign grp_end   = (pos_reg[mrdd_pkg::GROUP_W-1:0] == '1);
    assign next_slot = pos_reg[mrdd_pkg::GROUP_W-1:0] + mrdd_pkg::GROUP_W'(1);
    assign next_flag = header_reg[next_slot];
    assign run_stop  = rec_end || grp_end || next_flag;
    assign emit_half = rec_end && has_half;
    assign emit_word = emit_half
                     ? {{mrdd_pkg::HALF_W{1'b0}}, emit_val_reg[mrdd_pkg::HALF_W-1:0]}
                     : emit_val_reg;

    // ------------------------------------------------------------------
    // Store port control.
    // ------------------------------------------------------------------
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = pos_cur;
        if (state_reg == ST_IDLE && !cfg_fire && s_fire) begin
            if (phase_cur == PH_MASK) begin
                rd_en = 1'b1;
            end else if (phase_cur != PH_DATA) begin
                rd_en = !s_stream_byte[pos_cur[mrdd_pkg::GROUP_W-1:0]];
            end
        end else if (state_reg == ST_EMIT && out_free && !run_stop) begin
            rd_en   = 1'b1;
            rd_addr = pos_reg + mrdd_pkg::IDX_W'(1);
        end
    end

    assign wr_en = (state_reg == ST_EMIT) && out_free;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[pos_reg] <= emit_word;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
            rd_hit_reg  <= {1'b0, rd_addr} < fill_reg;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and output register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_HEADER;
            record_bytes_reg <= mrdd_pkg::RECORD_BYTES_RESET;
            pos_reg          <= '0;
            header_reg       <= '0;
            mask_reg         <= '0;
            fill_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            // drop the output item once taken; in EMIT the new item replaces it
            if (m_valid_reg && m_ready && state_reg != ST_EMIT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (cfg_fire) begin
                        // restart at word 0; keep the record store
                        record_bytes_reg <= cfg_data;
                        pos_reg          <= '0;
                        phase_reg        <= PH_HEADER;
                        mask_reg         <= '0;
                    end else if (s_fire) begin
                        pos_reg <= pos_cur;
                        case (phase_cur)
                            PH_MASK: begin
                                byte_reg  <= s_stream_byte;
                                state_reg <= ST_MASK_RD;
                            end
                            PH_DATA: begin
                                gathered_reg <= merged;
                                mask_reg     <= mask_left;
                                if (mask_left == '0) begin
                                    emit_val_reg <= merged;
                                    state_reg    <= ST_EMIT;
                                end
                            end
                            default: begin
                                // header byte: flagged slot waits for its mask,
                                // otherwise start copying unchanged words
                                header_reg <= s_stream_byte;
                                if (s_stream_byte[pos_cur[mrdd_pkg::GROUP_W-1:0]]) begin
                                    phase_reg <= PH_MASK;
                                end else begin
                                    phase_reg <= PH_HEADER;
                                    state_reg <= ST_COPY_RD;
                                end
                            end
                        endcase
                    end
                end

                ST_COPY_RD: begin
                    emit_val_reg <= rd_word;
                    state_reg    <= ST_EMIT;
                end

                ST_MASK_RD: begin
                    gathered_reg <= rd_word;
                    if (byte_reg == '0) begin
                        emit_val_reg <= rd_word;
                        state_reg    <= ST_EMIT;
                    end else begin
                        mask_reg  <= byte_reg;
                        phase_reg <= PH_DATA;
                        state_reg <= ST_IDLE;
                    end
                end

                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg       <= 1'b1;
                        m_word_value_reg  <= emit_word;
                        m_word_index_reg  <= pos_reg;
                        m_half_word_reg   <= emit_half;
                        m_record_end_reg  <= rec_end;
                        m_last_in_run_reg <= run_stop;
                        // writes arrive in position order, so the fill count
                        // only ever grows by one
                        if ({1'b0, pos_reg} == fill_reg) begin
                            fill_reg <= fill_reg + mrdd_pkg::FILL_W'(1);
                        end
                        if (rec_end) begin
                            pos_reg   <= '0;
                            phase_reg <= PH_HEADER;
                            state_reg <= ST_IDLE;
                        end else begin
                            pos_reg <= pos_reg + mrdd_pkg::IDX_W'(1);
                            if (grp_end) begin
                                phase_reg <= PH_HEADER;
                                state_reg <= ST_IDLE;
                            end else if (next_flag) begin
                                phase_reg <= PH_MASK;
                                state_reg <= ST_IDLE;
                            end else begin
                                phase_reg <= PH_HEADER;
                                state_reg <= ST_COPY_RD;
                            end
                        end
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/mrdd_checker.sv]
// Port-level checks for the masked record delta decoder, bound to the top level.
module mrdd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [mrdd_pkg::WORD_W-1:0]   m_word_value,
    input logic [mrdd_pkg::IDX_W-1:0]    m_word_index,
    input logic                          m_half_word,
    input logic                          m_record_end,
    input logic                          m_last_in_run
);

    logic                        seen_reg;
    logic                        prev_end_reg;
    logic                        prev_last_reg;
    logic [mrdd_pkg::IDX_W-1:0]  prev_idx_reg;

    // track the last taken output item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= 1'b0;
            prev_end_reg  <= 1'b0;
            prev_last_reg <= 1'b0;
            prev_idx_reg  <= '0;
        end else if (m_valid && m_ready) begin
            seen_reg      <= 1'b1;
            prev_end_reg  <= m_record_end;
            prev_last_reg <= m_last_in_run;
            prev_idx_reg  <= m_word_index;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word_value) && $stable(m_word_index))
        else $error("output item changed while stalled");

    a_half_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_half_word |-> m_record_end
            && m_word_value[mrdd_pkg::WORD_W-1:mrdd_pkg::HALF_W] == '0)
        else $error("half word not a zero-topped record tail");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && seen_reg && prev_end_reg |-> m_word_index == '0)
        else $error("word after record end not at index zero");

    a_run_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && seen_reg && !prev_end_reg && !prev_last_reg
            |-> m_word_index == prev_idx_reg + mrdd_pkg::IDX_W'(1))
        else $error("word within a run skipped a position");

    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cfg_valid && cfg_ready && s_valid && s_ready))
        else $error("configuration and byte taken together");

endmodule

bind masked_record_delta_decoder_unit mrdd_checker u_mrdd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_word_value  (m_word_value),
    .m_word_index  (m_word_index),
    .m_half_word   (m_half_word),
    .m_record_end  (m_record_end),
    .m_last_in_run (m_last_in_run)
);
